[rtl/rop_pkg.sv]
package rop_pkg;

  // Frame store geometry.
  localparam int MAX_SCREEN_W = 256;
  localparam int MAX_SCREEN_H = 256;
  localparam int FB_DEPTH     = MAX_SCREEN_W * MAX_SCREEN_H;
  localparam int FB_AW        = $clog2(FB_DEPTH);

  // Field and state widths.
  localparam int PIX_W   = 8;
  localparam int COORD_W = 8;
  localparam int DIM_W   = 9;
  localparam int POS_W   = 17;
  localparam int CNT_W   = 16;
  localparam int STEP_W  = $clog2(POS_W);

  localparam logic [POS_W-1:0] POS_MAX   = '1;
  localparam logic [DIM_W-1:0] LAYER_MAX = DIM_W'(256);

  // Register reset values.
  localparam logic [DIM_W-1:0] LAYER_W_RST  = DIM_W'(144);
  localparam logic [DIM_W-1:0] LAYER_H_RST  = DIM_W'(168);
  localparam logic [DIM_W-1:0] SCREEN_W_RST = DIM_W'(144);
  localparam logic [DIM_W-1:0] SCREEN_H_RST = DIM_W'(168);

  // Green, red and blue field sum at or above this paints a one.
  localparam logic [3:0] ONE_BIT_THRESH = 4'd4;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_WRITE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_COUNT_LO = 2'd0,
    PH_COUNT_HI = 2'd1,
    PH_COLOR    = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    CFG_LAYER_W  = 3'd0,
    CFG_LAYER_H  = 3'd1,
    CFG_ORIGIN_X = 3'd2,
    CFG_ORIGIN_Y = 3'd3,
    CFG_SCREEN_W = 3'd4,
    CFG_SCREEN_H = 3'd5,
    CFG_ONE_BIT  = 3'd6,
    CFG_TRANSP   = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_PAINT = 5'b00100,
    ST_READ  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0]   layer_w;
    logic [DIM_W-1:0]   layer_h;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [DIM_W-1:0]   screen_w;
    logic [DIM_W-1:0]   screen_h;
    logic               one_bit;
    logic [PIX_W-1:0]   transp;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic [PIX_W-1:0]   stream_byte;
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic [PIX_W-1:0]   pix_data;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] read_data;
    logic             area_full;
  } res_t;

  // Layer dimensions above the maximum behave as the maximum.
  function automatic logic [DIM_W-1:0] sat_layer(input logic [DIM_W-1:0] v);
    return (v > LAYER_MAX) ? LAYER_MAX : v;
  endfunction

  // Stored value of a painted pixel.
  function automatic logic [PIX_W-1:0] pixel_value(input logic [PIX_W-1:0] color,
                                                   input logic one_bit);
    logic [3:0] sum;
    sum = 4'(color[5:4]) + 4'(color[3:2]) + 4'(color[1:0]);
    if (!one_bit) return color;
    return (sum >= ONE_BIT_THRESH) ? PIX_W'(1) : PIX_W'(0);
  endfunction

  // Row-major frame store address.
  function automatic logic [FB_AW-1:0] fb_addr(input logic [DIM_W-1:0] x,
                                               input logic [DIM_W-1:0] y);
    return FB_AW'(int'(y) * MAX_SCREEN_W + int'(x));
  endfunction

endpackage

[rtl/rop_ram.sv]
module rop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/rop_div.sv]
module rop_div
  import rop_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [POS_W-1:0] dividend,
  input  logic [DIM_W-1:0] divisor,
  output logic             done,
  output logic [POS_W-1:0] quotient,
  output logic [DIM_W-1:0] remainder
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [POS_W-1:0]  quo;
  logic [DIM_W-1:0]  rem;
  logic [DIM_W-1:0]  dsr;
  logic [DIM_W:0]    trial;
  logic              fits;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
  assign trial = {rem, quo[POS_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(POS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[POS_W-2:0], fits};
      rem <= fits ? DIM_W'(trial - {1'b0, dsr}) : DIM_W'(trial);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[rtl/rop_core.sv]
module rop_core
  import rop_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  state_t             state;
  logic [POS_W-1:0]   pos;
  phase_t             phase;
  logic [CNT_W-1:0]   cnt;
  logic [PIX_W-1:0]   color_v;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [PIX_W-1:0]   rd;
  logic               in_store_q;
  logic [POS_W-1:0]   total;

  logic               accept;
  logic [DIM_W-1:0]   w_sat;
  logic [DIM_W-1:0]   h_sat;
  logic [DIM_W-1:0]   fx;
  logic [DIM_W-1:0]   fy;
  logic               visible;
  logic               in_store;
  logic [POS_W:0]     trans_sum;
  logic [DIM_W-1:0]   col_inc;
  logic [POS_W:0]     pos_inc;
  logic               last_paint;
  logic               div_start;
  logic               div_done;
  logic [POS_W-1:0]   div_quo;
  logic [DIM_W-1:0]   div_rem;
  logic               ram_we;
  logic [FB_AW-1:0]   ram_addr;
  logic [PIX_W-1:0]   ram_wdata;
  logic [PIX_W-1:0]   ram_rdata;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Layer area, registered off the configuration.
  assign w_sat = sat_layer(cfg.layer_w);
  assign h_sat = sat_layer(cfg.layer_h);

  always_ff @(posedge clk) begin
    total <= POS_W'(w_sat) * POS_W'(h_sat);
  end

  // Screen position of the pixel being painted, with clipping.
  assign fx = {1'b0, cfg.origin_x} + {1'b0, col};
  assign fy = {1'b0, cfg.origin_y} + {1'b0, row};
  assign visible = (fx < cfg.screen_w) && (int'(fx) < MAX_SCREEN_W) &&
                   (fy < cfg.screen_h) && (int'(fy) < MAX_SCREEN_H);
  assign in_store = (int'(in_item.pix_x) < MAX_SCREEN_W) &&
                    (int'(in_item.pix_y) < MAX_SCREEN_H);

  assign trans_sum  = {1'b0, pos} + (POS_W+1)'(cnt);
  assign col_inc    = {1'b0, col} + DIM_W'(1);
  assign pos_inc    = {1'b0, pos} + (POS_W+1)'(1);
  assign last_paint = (cnt == CNT_W'(1)) || (pos_inc >= {1'b0, total});

  // A colored run with pixels to paint first locates its start in the layer.
  assign div_start = accept && (in_item.mode == MODE_BYTE) &&
                     (phase != PH_COUNT_LO) && (phase != PH_COUNT_HI) &&
                     (in_item.stream_byte != cfg.transp) && (cnt != '0);

  rop_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (pos),
    .divisor   (w_sat),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Frame store port: the painter owns it while painting, the bus otherwise.
  always_comb begin
    if (state == ST_PAINT) begin
      ram_we    = visible;
      ram_addr  = fb_addr(fx, fy);
      ram_wdata = color_v;
    end else begin
      ram_we    = accept && (in_item.mode == MODE_WRITE) && in_store;
      ram_addr  = fb_addr({1'b0, in_item.pix_x}, {1'b0, in_item.pix_y});
      ram_wdata = in_item.pix_data;
    end
  end

  rop_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FB_DEPTH)
  ) u_fb (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Control state: decoder phase, position, pending count and sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
      phase <= PH_COUNT_LO;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_item.mode)
              MODE_START: begin
                state <= ST_DONE;
                pos   <= '0;
                phase <= PH_COUNT_LO;
                cnt   <= '0;
              end
              MODE_BYTE: begin
                case (phase)
                  PH_COUNT_LO: begin
                    state <= ST_DONE;
                    cnt   <= CNT_W'(in_item.stream_byte);
                    phase <= PH_COUNT_HI;
                  end
                  PH_COUNT_HI: begin
                    state <= ST_DONE;
                    cnt   <= {in_item.stream_byte, cnt[PIX_W-1:0]};
                    phase <= PH_COLOR;
                  end
                  default: begin
                    phase <= PH_COUNT_LO;
                    if (in_item.stream_byte == cfg.transp) begin
                      state <= ST_DONE;
                      pos <= (trans_sum > {1'b0, POS_MAX}) ? POS_MAX : trans_sum[POS_W-1:0];
                      cnt <= '0;
                    end else if (cnt != '0) begin
                      state <= ST_DIV;
                    end else begin
                      state <= ST_DONE;
                    end
                  end
                endcase
              end
              MODE_READ: begin
                state <= ST_READ;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (pos < total) begin
              state <= ST_PAINT;
            end else begin
              cnt   <= '0;
              state <= ST_DONE;
            end
          end
        end
        ST_PAINT: begin
          pos <= pos_inc[POS_W-1:0];
          if (last_paint) begin
            cnt   <= '0;
            state <= ST_DONE;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        ST_READ: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: run color, layer column and row, read data.
  always_ff @(posedge clk) begin
    if (accept) begin
      color_v    <= pixel_value(in_item.stream_byte, cfg.one_bit);
      rd         <= '0;
      in_store_q <= in_store;
    end
    if (state == ST_READ) begin
      rd <= in_store_q ? ram_rdata : '0;
    end
    if ((state == ST_DIV) && div_done) begin
      col <= div_rem[COORD_W-1:0];
      row <= div_quo[COORD_W-1:0];
    end
    if (state == ST_PAINT) begin
      if (col_inc == w_sat) begin
        col <= '0;
        row <= row + COORD_W'(1);
      end else begin
        col <= col_inc[COORD_W-1:0];
      end
    end
  end

  assign res_valid     = (state == ST_DONE);
  assign res.read_data = rd;
  assign res.area_full = (pos >= total);

endmodule

[rtl/rle_overlay_painter.sv]
// Channel   Signals                          Carries
// s_*       tvalid tready tdata[31:0] tuser  stream byte or pixel access in, mode in tuser
// m_*       tvalid tready tdata[15:0]        one result per input transfer
// cfg_*     valid ready index[2:0] data[8:0] register writes, always ready
//
// Start, count bytes, pixel writes: result goes via the done state, then the output register.
// Pixel reads: a registered frame store read and the ST_READ state come before the result.
// Colored run: the bit-serial divider locates the run start, then the painter writes
// one pixel per cycle, the single frame store port being the limit.
// Reset clears the decoder and the position; the frame store holds garbage until written.
// A held result keeps the core in its done state; no new input is taken until it moves on.
module rle_overlay_painter
  import rop_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // stream_byte[7:0], pix_x[15:8], pix_y[23:16], pix_data[31:24]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // read_data[7:0], area_full[8], zero[15:9]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  cfg_t  cfg;
  item_t item;
  res_t  res;
  res_t  out_res;
  logic  res_valid;
  logic  res_ready;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layer_w  <= LAYER_W_RST;
      cfg.layer_h  <= LAYER_H_RST;
      cfg.origin_x <= '0;
      cfg.origin_y <= '0;
      cfg.screen_w <= SCREEN_W_RST;
      cfg.screen_h <= SCREEN_H_RST;
      cfg.one_bit  <= 1'b0;
      cfg.transp   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LAYER_W:  cfg.layer_w  <= cfg_data;
        CFG_LAYER_H:  cfg.layer_h  <= cfg_data;
        CFG_ORIGIN_X: cfg.origin_x <= cfg_data[COORD_W-1:0];
        CFG_ORIGIN_Y: cfg.origin_y <= cfg_data[COORD_W-1:0];
        CFG_SCREEN_W: cfg.screen_w <= cfg_data;
        CFG_SCREEN_H: cfg.screen_h <= cfg_data;
        CFG_ONE_BIT:  cfg.one_bit  <= cfg_data[0];
        CFG_TRANSP:   cfg.transp   <= cfg_data[PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the input transfer.
  assign item.mode        = mode_t'(s_tuser);
  assign item.stream_byte = s_tdata[7:0];
  assign item.pix_x       = s_tdata[15:8];
  assign item.pix_y       = s_tdata[23:16];
  assign item.pix_data    = s_tdata[31:24];

  rop_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register between the core and the result channel.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'b0, out_res.area_full, out_res.read_data};

endmodule

[rtl/rop_checker.sv]
module rop_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Reset leaves the block ready for input with no result pending.
  a_reset_state: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

  // One item is worked on at a time: a transfer in closes intake for the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in progress");

  // A stalled result holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Padding above the area flag stays zero on every result.
  a_result_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:9] == 7'b0)
    else $error("result padding not zero");

endmodule

bind rle_overlay_painter rop_checker u_rop_checker (.*);
